// ----- rtl/lc3b_pkg.sv -----
`default_nettype none
package lc3b_pkg;

    localparam int MEM_WORDS = 32768;
    localparam int MEM_AW = $clog2(MEM_WORDS);

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_EXECUTE = 2'd3;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LDB  = 4'h2;
    localparam logic [3:0] OP_STB  = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDW  = 4'h6;
    localparam logic [3:0] OP_STW  = 4'h7;
    localparam logic [3:0] OP_XOR  = 4'h9;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_SHF  = 4'hD;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    localparam logic [2:0] CC_N = 3'b100;
    localparam logic [2:0] CC_Z = 3'b010;
    localparam logic [2:0] CC_P = 3'b001;

    // Memory port address selection.
    localparam logic [1:0] MA_ITEM  = 2'd0;
    localparam logic [1:0] MA_PC    = 2'd1;
    localparam logic [1:0] MA_DATA  = 2'd2;

    typedef struct packed {
        logic       load_item;   // capture input item
        logic [1:0] mem_sel;     // address source for the memory port
        logic       mem_read;
        logic       item_write;  // write command store
        logic       restart;
        logic       decode;      // latch instruction, compute address
        logic       data_write;  // STB / STW store
        logic       retire;      // register write-back and result capture
    } lc3b_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       pc_zero;
        logic       needs_data;  // LDB, LDW, STB, STW, TRAP
        logic       is_store;
    } lc3b_status_t;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        if (v[15]) return CC_N;
        else if (v == 16'd0) return CC_Z;
        else return CC_P;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lc3b_ctrl.sv -----
`default_nettype none
module lc3b_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  out_busy,
    input  wire lc3b_pkg::lc3b_status_t status,
    output lc3b_pkg::lc3b_cmd_t        cmd
);
    import lc3b_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ITEM   = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_DECODE = 3'd3;
    localparam logic [2:0] ST_DATA   = 3'd4;
    localparam logic [2:0] ST_RETIRE = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = ST_ITEM;
                end
            end
            ST_ITEM: begin
                // Memory read for a read command or the fetch is issued here.
                if (!out_busy) begin
                    unique case (status.command)
                        CMD_WRITE: begin
                            cmd.item_write = 1'b1;
                            cmd.mem_sel = MA_ITEM;
                            cmd.retire = 1'b1;
                            state_next = ST_IDLE;
                        end
                        CMD_READ: begin
                            cmd.mem_sel = MA_ITEM;
                            cmd.mem_read = 1'b1;
                            state_next = ST_RETIRE;
                        end
                        CMD_RESTART: begin
                            cmd.restart = 1'b1;
                            cmd.retire = 1'b1;
                            state_next = ST_IDLE;
                        end
                        default: begin
                            if (status.pc_zero) begin
                                cmd.retire = 1'b1;
                                state_next = ST_IDLE;
                            end else begin
                                cmd.mem_sel = MA_PC;
                                cmd.mem_read = 1'b1;
                                state_next = ST_FETCH;
                            end
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                cmd.decode = 1'b1;
                state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (status.needs_data) begin
                    cmd.mem_sel = MA_DATA;
                    cmd.mem_read = 1'b1;
                    state_next = ST_DATA;
                end else begin
                    cmd.retire = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DATA: begin
                if (status.is_store) begin
                    cmd.mem_sel = MA_DATA;
                    cmd.data_write = 1'b1;
                end
                cmd.retire = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RETIRE: begin
                cmd.retire = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.retire |-> !out_busy)
        else $error("retire while result register is full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_item |=> !s_ready)
        else $error("ready held after a transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.data_write || cmd.item_write) |-> !cmd.mem_read)
        else $error("read and write in the same cycle");

endmodule
`default_nettype wire

// ----- rtl/lc3b_dp.sv -----
`default_nettype none
module lc3b_dp (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire lc3b_pkg::lc3b_cmd_t    cmd,
    output lc3b_pkg::lc3b_status_t      status,
    input  wire logic [15:0]            start_pc,
    input  wire logic [1:0]             s_command,
    input  wire logic [14:0]            s_word_address,
    input  wire logic [15:0]            s_write_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        out_busy,
    output logic [15:0]                 m_program_counter,
    output logic                        m_flag_negative,
    output logic                        m_flag_zero,
    output logic                        m_flag_positive,
    output logic                        m_halted,
    output logic                        m_reg_written,
    output logic [2:0]                  m_dest_index,
    output logic [15:0]                 m_dest_value,
    output logic                        m_mem_written,
    output logic [15:0]                 m_read_data
);
    import lc3b_pkg::*;

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rdata_reg;

    logic [1:0]  cmd_reg;
    logic [14:0] waddr_reg;
    logic [15:0] wdata_reg;
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  cc_reg, cc_next;
    logic [15:0] rf_reg [8];
    logic [15:0] ir_reg;
    logic [15:0] addr_reg;
    logic [15:0] a_reg;
    logic [15:0] st_reg;

    logic [3:0]  op;
    logic [2:0]  dr;
    logic [15:0] b_val, pc2;
    logic [15:0] ea_next;

    logic [MEM_AW-1:0] mem_addr;
    logic [15:0]       mem_wdata;

    // Decode of the latched instruction.
    assign op  = ir_reg[15:12];
    assign dr  = ir_reg[11:9];
    assign pc2 = pc_reg + 16'd2;

    always_comb begin
        unique case (cmd.mem_sel)
            MA_ITEM: mem_addr = waddr_reg[MEM_AW-1:0];
            MA_PC:   mem_addr = pc_reg[MEM_AW:1];
            default: mem_addr = addr_reg[MEM_AW:1];
        endcase
    end

    always_comb begin
        mem_wdata = st_reg;
        if (op == OP_STB) begin
            if (addr_reg[0]) mem_wdata = {st_reg[7:0], rdata_reg[7:0]};
            else             mem_wdata = {rdata_reg[15:8], st_reg[7:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_write) begin
            mem[mem_addr] <= wdata_reg;
        end else if (cmd.data_write) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_read) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_reg   <= s_command;
            waddr_reg <= s_word_address;
            wdata_reg <= s_write_data;
        end
    end

    // Effective address and operands from the fetched word.
    logic [15:0] ir_w, a_w;
    always_comb begin
        ir_w = rdata_reg;
        a_w = rf_reg[ir_w[8:6]];
        unique case (ir_w[15:12])
            OP_LDB, OP_STB: ea_next = a_w + {{10{ir_w[5]}}, ir_w[5:0]};
            OP_LDW, OP_STW: ea_next = a_w + {{9{ir_w[5]}}, ir_w[5:0], 1'b0};
            default:        ea_next = {7'd0, ir_w[7:0], 1'b0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            ir_reg   <= ir_w;
            addr_reg <= ea_next;
            a_reg    <= a_w;
            st_reg   <= rf_reg[ir_w[11:9]];
        end
    end

    always_comb begin
        b_val = ir_reg[5] ? {{11{ir_reg[4]}}, ir_reg[4:0]} : rf_reg[ir_reg[2:0]];
    end

    // Write-back.
    logic        regw, setcc;
    logic [2:0]  dest;
    logic [15:0] res, pc_new;
    logic [15:0] sra;
    logic        memw;
    always_comb begin
        regw = 1'b0;
        setcc = 1'b0;
        memw = 1'b0;
        dest = dr;
        res = 16'd0;
        pc_new = pc2;
        sra = 16'($signed(a_reg) >>> ir_reg[3:0]);
        unique case (op)
            OP_BR: begin
                if ((dr & cc_reg) != 3'd0)
                    pc_new = pc2 + {{6{ir_reg[8]}}, ir_reg[8:0], 1'b0};
            end
            OP_ADD: begin res = a_reg + b_val; regw = 1'b1; setcc = 1'b1; end
            OP_AND: begin res = a_reg & b_val; regw = 1'b1; setcc = 1'b1; end
            OP_XOR: begin res = a_reg ^ b_val; regw = 1'b1; setcc = 1'b1; end
            OP_LDB: begin
                res = addr_reg[0] ? {{8{rdata_reg[15]}}, rdata_reg[15:8]}
                                  : {{8{rdata_reg[7]}}, rdata_reg[7:0]};
                regw = 1'b1; setcc = 1'b1;
            end
            OP_LDW: begin res = rdata_reg; regw = 1'b1; setcc = 1'b1; end
            OP_STB, OP_STW: memw = 1'b1;
            OP_JSR: begin
                res = pc2; regw = 1'b1; dest = 3'd7;
                pc_new = ir_reg[11] ? pc2 + {{4{ir_reg[10]}}, ir_reg[10:0], 1'b0}
                                    : a_reg;
            end
            OP_JMP: pc_new = a_reg;
            OP_SHF: begin
                if (!ir_reg[4])      res = a_reg << ir_reg[3:0];
                else if (!ir_reg[5]) res = a_reg >> ir_reg[3:0];
                else                 res = sra;
                regw = 1'b1; setcc = 1'b1;
            end
            OP_LEA: begin
                res = pc2 + {{6{ir_reg[8]}}, ir_reg[8:0], 1'b0}; regw = 1'b1;
            end
            OP_TRAP: begin
                res = pc2; regw = 1'b1; dest = 3'd7; pc_new = rdata_reg;
            end
            default: ;
        endcase
    end

    logic is_exec, is_halt;
    assign is_exec = (cmd_reg == CMD_EXECUTE) && (pc_reg != 16'd0);
    assign is_halt = (cmd_reg == CMD_EXECUTE) && (pc_reg == 16'd0);

    always_comb begin
        pc_next = pc_reg;
        cc_next = cc_reg;
        if (cmd.restart) begin
            pc_next = start_pc;
            cc_next = CC_Z;
        end else if (cmd.retire && is_exec) begin
            pc_next = pc_new;
            if (setcc) cc_next = cc_of(res);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= 16'd0;
            cc_reg <= CC_Z;
            for (int i = 0; i < 8; i++) rf_reg[i] <= 16'd0;
        end else begin
            pc_reg <= pc_next;
            cc_reg <= cc_next;
            if (cmd.retire && is_exec && regw) rf_reg[dest] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.retire) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.retire) begin
            m_program_counter <= pc_next;
            m_flag_negative   <= cc_next[2];
            m_flag_zero       <= cc_next[1];
            m_flag_positive   <= cc_next[0];
            m_halted          <= is_halt;
            m_reg_written     <= is_exec && regw;
            m_dest_index      <= (is_exec && regw) ? dest : 3'd0;
            m_dest_value      <= (is_exec && regw) ? res : 16'd0;
            m_mem_written     <= is_exec && memw;
            m_read_data       <= (cmd_reg == CMD_READ) ? rdata_reg : 16'd0;
        end
    end

    assign out_busy = m_valid && !m_ready;

    assign status.command    = cmd_reg;
    assign status.pc_zero    = (pc_reg == 16'd0);
    assign status.needs_data = (ir_reg[15:12] == OP_LDB) || (ir_reg[15:12] == OP_LDW)
                            || (ir_reg[15:12] == OP_STB) || (ir_reg[15:12] == OP_STW)
                            || (ir_reg[15:12] == OP_TRAP);
    assign status.is_store   = (op == OP_STB) || (op == OP_STW);

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(cc_reg))
        else $error("condition codes not one-hot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.restart |=> (pc_reg == $past(start_pc)))
        else $error("restart did not load the PC");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_program_counter))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

// ----- rtl/lc3b_instruction_execute.sv -----
// LC-3b core with a private 32K-word memory.
// Input channel (s_valid/s_ready) carries one command per transfer: write a
// memory word, read a memory word, restart, or execute one instruction.
// Result channel (m_valid/m_ready) returns one result per command.
// The configuration channel (cfg_valid/cfg_ready) is always ready and writes
// start_pc; the user must do so only while the core is idle (not enforced).
// Write and restart retire from the item state and a read retires after its
// memory read; an execute fetches and decodes, and loads, stores and TRAP add
// a data access before retiring. Execute with the PC at zero reports halted
// from the item state. The single-port memory sets the rate: one access per
// cycle for fetch, data read and store. One command is in flight at a time;
// the next transfer is taken in the cycle after the result is written to
// the output register.
// Reset clears the PC, the registers and start_pc and sets the Z flag; the
// memory holds whatever it held until written.
// A stalled receiver holds the result register and the controller waits
// before retiring the next command.
`default_nettype none
module lc3b_instruction_execute (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [14:0] s_word_address,
    input  wire logic [15:0] s_write_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_program_counter,
    output logic             m_flag_negative,
    output logic             m_flag_zero,
    output logic             m_flag_positive,
    output logic             m_halted,
    output logic             m_reg_written,
    output logic [2:0]       m_dest_index,
    output logic [15:0]      m_dest_value,
    output logic             m_mem_written,
    output logic [15:0]      m_read_data
);
    import lc3b_pkg::*;

    lc3b_cmd_t    cmd;
    lc3b_status_t status;
    logic         out_busy;
    logic [15:0]  start_pc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pc_reg <= 16'd0;
        end else if (cfg_valid) begin
            start_pc_reg <= cfg_data;
        end
    end

    lc3b_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_busy (out_busy),
        .status   (status),
        .cmd      (cmd)
    );

    lc3b_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .start_pc          (start_pc_reg),
        .s_command         (s_command),
        .s_word_address    (s_word_address),
        .s_write_data      (s_write_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .out_busy          (out_busy),
        .m_program_counter (m_program_counter),
        .m_flag_negative   (m_flag_negative),
        .m_flag_zero       (m_flag_zero),
        .m_flag_positive   (m_flag_positive),
        .m_halted          (m_halted),
        .m_reg_written     (m_reg_written),
        .m_dest_index      (m_dest_index),
        .m_dest_value      (m_dest_value),
        .m_mem_written     (m_mem_written),
        .m_read_data       (m_read_data)
    );

endmodule
`default_nettype wire

// ----- tb/tb_lc3b_instruction_execute.sv -----
`default_nettype none
module tb_lc3b_instruction_execute;
    timeunit 1ns;
    timeprecision 1ps;

    import lc3b_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [15:0] program_counter;
        logic        flag_negative;
        logic        flag_zero;
        logic        flag_positive;
        logic        halted;
        logic        reg_written;
        logic [2:0]  dest_index;
        logic [15:0] dest_value;
        logic        mem_written;
        logic [15:0] read_data;
    } core_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [14:0] s_word_address = '0;
    logic [15:0] s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_program_counter;
    logic        m_flag_negative;
    logic        m_flag_zero;
    logic        m_flag_positive;
    logic        m_halted;
    logic        m_reg_written;
    logic [2:0]  m_dest_index;
    logic [15:0] m_dest_value;
    logic        m_mem_written;
    logic [15:0] m_read_data;

    logic [15:0] mem_image [MEM_WORDS];
    bit          mem_known [MEM_WORDS];
    logic [14:0] known_words [$];
    logic [15:0] cpu_gpr [8];
    logic [15:0] cpu_pc;
    logic [2:0]  cpu_cc;
    logic [15:0] start_addr;

    core_result_t pending_results [$];
    int  errors;
    int  cycles;
    int  hold_cycles;
    bit  sender_idles;
    bit  receiver_idles;

    lc3b_instruction_execute u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_word_address    (s_word_address),
        .s_write_data      (s_write_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_program_counter (m_program_counter),
        .m_flag_negative   (m_flag_negative),
        .m_flag_zero       (m_flag_zero),
        .m_flag_positive   (m_flag_positive),
        .m_halted          (m_halted),
        .m_reg_written     (m_reg_written),
        .m_dest_index      (m_dest_index),
        .m_dest_value      (m_dest_value),
        .m_mem_written     (m_mem_written),
        .m_read_data       (m_read_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void store_word(logic [14:0] idx, logic [15:0] value);
        mem_image[idx] = value;
        if (!mem_known[idx]) begin
            mem_known[idx] = 1'b1;
            known_words.push_back(idx);
        end
    endfunction

    function automatic core_result_t apply_command(logic [1:0] cmd, logic [14:0] waddr,
                                                   logic [15:0] wdata);
        core_result_t r;
        logic [15:0]  ir, a, b, res, addr, word;
        logic [3:0]   op;
        logic [2:0]   dr;
        logic         regw, cc_upd;
        r = '0;
        case (cmd)
            CMD_WRITE: store_word(waddr, wdata);
            CMD_READ: r.read_data = mem_image[waddr];
            CMD_RESTART: begin
                cpu_pc = start_addr;
                cpu_cc = CC_Z;
            end
            default: begin
                if (cpu_pc == 16'd0) begin
                    r.halted = 1'b1;
                end else begin
                    ir = mem_image[cpu_pc[15:1]];
                    op = ir[15:12];
                    dr = ir[11:9];
                    a = cpu_gpr[ir[8:6]];
                    b = ir[5] ? {{11{ir[4]}}, ir[4:0]} : cpu_gpr[ir[2:0]];
                    res = '0;
                    regw = 1'b0;
                    cc_upd = 1'b0;
                    cpu_pc = cpu_pc + 16'd2;
                    case (op)
                        OP_BR: begin
                            if ((dr & cpu_cc) != 3'b000)
                                cpu_pc = cpu_pc + {{6{ir[8]}}, ir[8:0], 1'b0};
                        end
                        OP_ADD: begin res = a + b; regw = 1'b1; cc_upd = 1'b1; end
                        OP_AND: begin res = a & b; regw = 1'b1; cc_upd = 1'b1; end
                        OP_XOR: begin res = a ^ b; regw = 1'b1; cc_upd = 1'b1; end
                        OP_LDB: begin
                            addr = a + {{10{ir[5]}}, ir[5:0]};
                            word = mem_image[addr[15:1]];
                            res = addr[0] ? {{8{word[15]}}, word[15:8]}
                                          : {{8{word[7]}}, word[7:0]};
                            regw = 1'b1;
                            cc_upd = 1'b1;
                        end
                        OP_STB: begin
                            addr = a + {{10{ir[5]}}, ir[5:0]};
                            word = mem_image[addr[15:1]];
                            if (addr[0])
                                word[15:8] = cpu_gpr[dr][7:0];
                            else
                                word[7:0] = cpu_gpr[dr][7:0];
                            store_word(addr[15:1], word);
                            r.mem_written = 1'b1;
                        end
                        OP_LDW: begin
                            addr = a + {{9{ir[5]}}, ir[5:0], 1'b0};
                            res = mem_image[addr[15:1]];
                            regw = 1'b1;
                            cc_upd = 1'b1;
                        end
                        OP_STW: begin
                            addr = a + {{9{ir[5]}}, ir[5:0], 1'b0};
                            store_word(addr[15:1], cpu_gpr[dr]);
                            r.mem_written = 1'b1;
                        end
                        OP_JSR: begin
                            res = cpu_pc;
                            if (ir[11])
                                cpu_pc = cpu_pc + {{4{ir[10]}}, ir[10:0], 1'b0};
                            else
                                cpu_pc = a;
                            dr = 3'd7;
                            regw = 1'b1;
                        end
                        OP_JMP: cpu_pc = a;
                        OP_SHF: begin
                            if (!ir[4])
                                res = a << ir[3:0];
                            else if (!ir[5])
                                res = a >> ir[3:0];
                            else
                                res = $signed(a) >>> ir[3:0];
                            regw = 1'b1;
                            cc_upd = 1'b1;
                        end
                        OP_LEA: begin
                            res = cpu_pc + {{6{ir[8]}}, ir[8:0], 1'b0};
                            regw = 1'b1;
                        end
                        OP_TRAP: begin
                            res = cpu_pc;
                            dr = 3'd7;
                            regw = 1'b1;
                            cpu_pc = mem_image[{7'd0, ir[7:0]}];
                        end
                        default: ;
                    endcase
                    if (regw) begin
                        cpu_gpr[dr] = res;
                        r.reg_written = 1'b1;
                        r.dest_index = dr;
                        r.dest_value = res;
                        if (cc_upd)
                            cpu_cc = res[15] ? CC_N : (res == 16'd0 ? CC_Z : CC_P);
                    end
                end
            end
        endcase
        r.program_counter = cpu_pc;
        r.flag_negative = cpu_cc[2];
        r.flag_zero = cpu_cc[1];
        r.flag_positive = cpu_cc[0];
        return r;
    endfunction

    // Word that the instruction at the PC will read or partly rewrite, if any.
    function automatic bit data_word(output logic [14:0] idx);
        logic [15:0] ir, a, addr;
        ir = mem_image[cpu_pc[15:1]];
        a = cpu_gpr[ir[8:6]];
        idx = '0;
        case (ir[15:12])
            OP_LDB, OP_STB: addr = a + {{10{ir[5]}}, ir[5:0]};
            OP_LDW: addr = a + {{9{ir[5]}}, ir[5:0], 1'b0};
            OP_TRAP: addr = {7'd0, ir[7:0], 1'b0};
            default: return 1'b0;
        endcase
        idx = addr[15:1];
        return 1'b1;
    endfunction

    task automatic send_command(logic [1:0] cmd, logic [14:0] waddr, logic [15:0] wdata);
        while (sender_idles && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_word_address <= waddr;
        s_write_data <= wdata;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_command(cmd, waddr, wdata));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_start_pc(logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_addr = value;
        @(posedge aclk);
    endtask

    task automatic step_program();
        logic [14:0] idx;
        if (cpu_pc != 16'd0) begin
            if (!mem_known[cpu_pc[15:1]])
                send_command(CMD_WRITE, cpu_pc[15:1], 16'($urandom));
            if (data_word(idx) && !mem_known[idx])
                send_command(CMD_WRITE, idx, 16'($urandom));
        end
        send_command(CMD_EXECUTE, 15'($urandom), 16'($urandom));
    endtask

    task automatic run_instruction(logic [15:0] ir);
        if (cpu_pc != 16'd0)
            send_command(CMD_WRITE, cpu_pc[15:1], ir);
        step_program();
    endtask

    task automatic test_memory_port();
        send_command(CMD_WRITE, 15'd0, 16'hFFFF);
        send_command(CMD_WRITE, 15'h7FFF, 16'h0000);
        send_command(CMD_WRITE, 15'h5555, 16'hAAAA);
        send_command(CMD_READ, 15'd0, 16'h5555);
        send_command(CMD_READ, 15'h7FFF, 16'hFFFF);
        send_command(CMD_READ, 15'h5555, 16'd0);
    endtask

    task automatic test_halt();
        step_program();
        send_command(CMD_RESTART, 15'h7FFF, 16'hFFFF);
        step_program();
    endtask

    task automatic test_opcodes();
        write_start_pc(16'h3000);
        send_command(CMD_RESTART, 15'd0, 16'd0);
        run_instruction({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h1F});
        run_instruction({OP_ADD, 3'd2, 3'd1, 3'b000, 3'd1});
        run_instruction({OP_AND, 3'd3, 3'd1, 1'b1, 5'h0F});
        run_instruction({OP_XOR, 3'd4, 3'd1, 3'b000, 3'd3});
        run_instruction({OP_SHF, 3'd5, 3'd1, 2'b00, 4'hF});
        run_instruction({OP_SHF, 3'd5, 3'd1, 2'b01, 4'h3});
        run_instruction({OP_SHF, 3'd5, 3'd1, 2'b11, 4'h4});
        run_instruction({OP_SHF, 3'd5, 3'd1, 2'b11, 4'h0});
        run_instruction({OP_LEA, 3'd6, 9'h1FF});
        run_instruction({OP_STW, 3'd1, 3'd0, 6'h20});
        run_instruction({OP_LDW, 3'd2, 3'd0, 6'h20});
        run_instruction({OP_STB, 3'd4, 3'd1, 6'h00});
        run_instruction({OP_LDB, 3'd3, 3'd1, 6'h00});
        run_instruction({OP_BR, 3'b111, 9'd3});
        run_instruction({OP_BR, 3'b000, 9'h1F0});
        run_instruction({OP_JSR, 1'b1, 11'h004});
        run_instruction({OP_JSR, 1'b0, 2'b00, 3'd7, 6'd0});
        run_instruction({OP_JMP, 3'd0, 3'd6, 6'd0});
        run_instruction({4'h8, 12'hFFF});
        run_instruction({4'hA, 12'h000});
        run_instruction({4'hB, 12'h5A5});
        run_instruction({OP_TRAP, 4'd0, 8'h25});
    endtask

    task automatic test_start_pc_extremes();
        write_start_pc(16'hFFFF);
        send_command(CMD_RESTART, 15'd0, 16'd0);
        run_instruction({OP_ADD, 3'd0, 3'd0, 1'b1, 5'h01});
        write_start_pc(16'h0000);
        send_command(CMD_RESTART, 15'd0, 16'd0);
        step_program();
        write_start_pc(16'h0001);
        send_command(CMD_RESTART, 15'd0, 16'd0);
        step_program();
    endtask

    task automatic test_random_program(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                step_program();
            else if (pick < 80)
                send_command(CMD_WRITE, cpu_pc[15:1] + 15'($urandom_range(3)), 16'($urandom));
            else if (pick < 88)
                send_command(CMD_READ, known_words[$urandom_range(known_words.size() - 1)],
                             16'($urandom));
            else if (pick < 95)
                send_command(CMD_RESTART, 15'($urandom), 16'($urandom));
            else
                send_command(CMD_WRITE, 15'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_backpressure();
        @(posedge aclk);
        hold_cycles = 200;
        for (int i = 0; i < 20; i++)
            step_program();
    endtask

    task automatic test_drain_pause();
        wait_drained();
        for (int i = 0; i < 10; i++)
            step_program();
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= receiver_idles ? ($urandom_range(99) >= 37) : 1'b1;
        end
    end

    task automatic check_field(string name, logic [15:0] expected_val, logic [15:0] actual);
        if (expected_val !== actual) begin
            $error("%s: expected %h, got %h", name, expected_val, actual);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        core_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no command outstanding");
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("program_counter", e.program_counter, m_program_counter);
                check_field("flag_negative", e.flag_negative, m_flag_negative);
                check_field("flag_zero", e.flag_zero, m_flag_zero);
                check_field("flag_positive", e.flag_positive, m_flag_positive);
                check_field("halted", e.halted, m_halted);
                check_field("reg_written", e.reg_written, m_reg_written);
                check_field("dest_index", e.dest_index, m_dest_index);
                check_field("dest_value", e.dest_value, m_dest_value);
                check_field("mem_written", e.mem_written, m_mem_written);
                check_field("read_data", e.read_data, m_read_data);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lc3b_instruction_execute test failed");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        for (int i = 0; i < 8; i++)
            cpu_gpr[i] = '0;
        cpu_pc = '0;
        cpu_cc = CC_Z;
        start_addr = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_memory_port();
        test_halt();
        test_opcodes();
        test_start_pc_extremes();
        for (int phase = 0; phase < 4; phase++) begin
            write_start_pc(16'($urandom) & 16'hFFFE | 16'h0100);
            send_command(CMD_RESTART, 15'($urandom), 16'($urandom));
            if (phase == 2) begin
                sender_idles = 1'b0;
                receiver_idles = 1'b0;
            end
            test_random_program(85);
            sender_idles = 1'b1;
            receiver_idles = 1'b1;
        end
        test_backpressure();
        test_drain_pause();

        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("lc3b_instruction_execute test passed");
        else
            $display("lc3b_instruction_execute test failed");
        $finish;
    end
endmodule
`default_nettype wire
